[rtl/quadrature_encoder_key_scanner_defines.svh]
// Assertion helpers shared by the scanner RTL.
`ifndef QUADRATURE_ENCODER_KEY_SCANNER_DEFINES_SVH
`define QUADRATURE_ENCODER_KEY_SCANNER_DEFINES_SVH

// Check on every clock edge outside of reset.
`define QEKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define QEKS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/qeks_pkg.sv]
`default_nettype none
package qeks_pkg;

  localparam int unsigned Channels   = 12;
  localparam int unsigned ReportKeys = 6;

  localparam int unsigned EncPinW  = 24;
  localparam int unsigned BtnPinW  = 12;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned KeyW     = 8;
  localparam int unsigned KeyCntW  = 3;
  localparam int unsigned SlotNum  = 6;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutPadW  = OutDataW - KeyCntW - SlotNum * KeyW - 2;

  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] CfgEncBase = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgBtnBase = 1'b1;

  localparam logic [KeyW-1:0] EncBaseRst = 8'd4;
  localparam logic [KeyW-1:0] BtnBaseRst = 8'd84;

  localparam logic [3:0] BootMask = 4'hF;
  localparam logic [3:0] BootCode = 4'h6;

  // successor phase, entry p at bits 2p+1..2p
  localparam logic [3:0][1:0] FwdNext = {2'd1, 2'd3, 2'd0, 2'd2};
  localparam logic [3:0][1:0] BwdNext = {2'd2, 2'd0, 2'd3, 2'd1};

endpackage
`default_nettype wire

[rtl/quadrature_encoder_key_scanner.sv]
// StIdle takes the input word, StEnc scans the encoders and StBtn the buttons, and StLoad
// writes the result word once the output register is free; only then is a new word taken.
// The shared key-code adder visits one encoder or one button per cycle.
// A finished result waits in the output register while the next word is accepted.
// Reset: asynchronous, active low; stored phases and levels clear to zero and the
// key bases return to 4 and 84.
`default_nettype none
`include "quadrature_encoder_key_scanner_defines.svh"
module quadrature_encoder_key_scanner #(
  parameter int unsigned CHANNELS    = qeks_pkg::Channels,
  parameter int unsigned REPORT_KEYS = qeks_pkg::ReportKeys
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [qeks_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [qeks_pkg::KeyW-1:0]     cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // encoder_pins[23:0], button_pins[35:24], zero pad
  input  wire logic [qeks_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // key_count[2:0], key_first .. key_sixth[50:3], keys_dropped[51],
  // boot_request[52], zero pad
  output logic [qeks_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import qeks_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(2 * CHANNELS + 1);
  localparam int unsigned CmpW = (CntW > 5) ? CntW : 5;
  localparam logic [IdxW-1:0]    IdxLast = IdxW'(CHANNELS - 1);
  localparam logic [CmpW-1:0]    RkCmp   = CmpW'(REPORT_KEYS);
  localparam logic [KeyCntW-1:0] RkCnt   = KeyCntW'(REPORT_KEYS);

  typedef enum logic [1:0] {StIdle, StEnc, StBtn, StLoad} state_e;

  state_e                       state_q, state_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [EncPinW-1:0]           enc_q, enc_d;
  logic [BtnPinW-1:0]           btn_q, btn_d;
  logic [CHANNELS-1:0][1:0]     phase_q, phase_d;
  logic [CHANNELS-1:0]          lvl_q, lvl_d;
  logic [SlotNum-1:0][KeyW-1:0] slot_q, slot_d;
  logic                         out_vld_q, out_vld_d;
  logic [KeyCntW-1:0]           kcnt_q, kcnt_d;
  logic [SlotNum-1:0][KeyW-1:0] kslot_q, kslot_d;
  logic                         drop_q, drop_d;
  logic                         boot_q, boot_d;
  logic [KeyW-1:0]              enc_base_q, btn_base_q;

  logic [EncPinW-1:0] enc_sh;
  logic [BtnPinW-1:0] btn_sh;
  logic [1:0]         now_ph, old_ph;
  logic               now_lvl, fwd_hit, bwd_hit, press, emit;
  logic [KeyW-1:0]    add_base, add_off, code;
  logic [CmpW-1:0]    cnt_ext, shown;
  logic               slot_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_base_q <= EncBaseRst;
      btn_base_q <= BtnBaseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgEncBase: enc_base_q <= cfg_wdata_i;
        CfgBtnBase: btn_base_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    enc_sh  = enc_q >> {idx_q, 1'b0};
    btn_sh  = btn_q >> idx_q;
    now_ph  = enc_sh[1:0];
    now_lvl = btn_sh[0];
    old_ph  = phase_q[idx_q];
    fwd_hit = (now_ph != old_ph) && (FwdNext[old_ph] == now_ph);
    bwd_hit = (now_ph != old_ph) && (BwdNext[old_ph] == now_ph);
    press   = !now_lvl && lvl_q[idx_q];
    emit    = ((state_q == StEnc) && (fwd_hit || bwd_hit)) ||
              ((state_q == StBtn) && press);

    add_base = (state_q == StBtn) ? btn_base_q : enc_base_q;
    add_off  = KeyW'(idx_q) +
               (((state_q == StEnc) && bwd_hit) ? KeyW'(CHANNELS) : KeyW'(0));
    code     = add_base + add_off;

    cnt_ext = CmpW'(cnt_q);
    slot_en = (cnt_ext < RkCmp) && (cnt_ext < CmpW'(SlotNum));
    shown   = (cnt_ext < RkCmp) ? cnt_ext : RkCmp;
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    enc_d     = enc_q;
    btn_d     = btn_q;
    phase_d   = phase_q;
    lvl_d     = lvl_q;
    slot_d    = slot_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    kcnt_d    = kcnt_q;
    kslot_d   = kslot_q;
    drop_d    = drop_q;
    boot_d    = boot_q;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          enc_d   = s_axis_tdata_i[EncPinW-1:0];
          btn_d   = s_axis_tdata_i[EncPinW +: BtnPinW];
          idx_d   = '0;
          cnt_d   = '0;
          slot_d  = '0;
          state_d = StEnc;
        end
      end
      StEnc: begin
        phase_d[idx_q] = now_ph;
        if (idx_q == IdxLast) begin
          idx_d   = '0;
          state_d = StBtn;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StBtn: begin
        lvl_d[idx_q] = now_lvl;
        if (idx_q == IdxLast) begin
          idx_d   = '0;
          state_d = StLoad;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StLoad: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          kcnt_d    = shown[KeyCntW-1:0];
          kslot_d   = slot_q;
          drop_d    = cnt_ext > RkCmp;
          boot_d    = (btn_q[3:0] & BootMask) == BootCode;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (emit) begin
      if (slot_en) begin
        slot_d[cnt_ext[2:0]] = code;
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      idx_q     <= '0;
      cnt_q     <= '0;
      enc_q     <= '0;
      btn_q     <= '0;
      phase_q   <= '0;
      lvl_q     <= '0;
      slot_q    <= '0;
      out_vld_q <= 1'b0;
      kcnt_q    <= '0;
      kslot_q   <= '0;
      drop_q    <= 1'b0;
      boot_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      enc_q     <= enc_d;
      btn_q     <= btn_d;
      phase_q   <= phase_d;
      lvl_q     <= lvl_d;
      slot_q    <= slot_d;
      out_vld_q <= out_vld_d;
      kcnt_q    <= kcnt_d;
      kslot_q   <= kslot_d;
      drop_q    <= drop_d;
      boot_q    <= boot_d;
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {OutPadW'(0), boot_q, drop_q, kslot_q, kcnt_q};

  `QEKS_ASSERT(a_start_scan,
    s_axis_tvalid_i && s_axis_tready_o |=> state_q == StEnc && cnt_q == '0 && idx_q == '0,
    "scan did not start clean after accept")
  `QEKS_ASSERT(a_cnt_step,
    state_q == StEnc || state_q == StBtn |=>
      cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1,
    "event count moved by more than one")
  `QEKS_ASSERT(a_drop_full,
    m_axis_tvalid_o && drop_q |-> kcnt_q == RkCnt,
    "dropped keys with a report that is not full")
  `QEKS_ASSERT_RST(a_rst_quiet,
    !rst_ni |-> !m_axis_tvalid_o,
    "result word valid during reset")

endmodule
`default_nettype wire
